// ===== src/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

   // screen geometry
   localparam int ROWS      = 25;
   localparam int COLS      = 80;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = ROWS * COLS;

   // field widths
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   localparam int ADDR_W  = $clog2(CELLS);
   localparam int PHASE_W = $clog2(TAB_WIDTH);

   // operation codes
   localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NULL  = 8'h00;

   // controller -> datapath
   typedef struct packed {
      logic accept;       // capture request payload
      logic sweep_clear;  // write space at linear sweep address, step sweep
      logic scroll_fill;  // write zero into top physical row, step sweep
      logic scroll_end;   // rotate top row pointer, cursor row up one
      logic pad;          // write space at cursor, advance cursor
      logic put;          // write character at cursor, advance cursor
      logic read;         // read addressed cell
      logic home;         // cursor and top pointer to zero
      logic finish;       // load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_tab;
      logic            is_nl;
      logic            row_at_end;   // cursor row equals ROWS
      logic            row_last;     // cursor row equals ROWS-1
      logic            col_last;     // cursor column equals COLS-1
      logic            col_ge_tab;   // column at or beyond last tab stop
      logic            phase_last;   // next column is a tab stop
      logic            sweep_last_cell;
      logic            sweep_last_col;
      logic            rsp_free;
   } status_type;

endpackage

// ===== src/text_console_char_writer_unit.sv =====
`timescale 1ns / 1ps
// Text console character writer: 25 x 80 character screen with a cursor.
// Request channel (req_*): op selects print (char_code), read cell
// (read_row, read_column) or clear screen. A transfer happens when req_valid
// is high and req_stall is low; one request is worked on at a time.
// Response channel (rsp_*): exactly one transfer per request, carrying the
// read cell (zero for other ops) and the cursor after the request.
// Work done between request transfer and response valid:
//   ordinary character       written at the cursor
//   tab                      spaces up to the next tab stop, or as newline
//   newline                  spaces padded to the end of the row
//   scroll (row 25 pending)  one row zero-filled, once per print
//   read                     one registered cell read; unused op code none
//   clear                    spaces into every cell, one cell per cycle
// Scrolling rotates a top-row pointer and zero-fills one row, so its cost
// is one row, not the whole screen. The screen is a single-port-write,
// registered-read memory; all cell work goes one cell per cycle.
// After reset the block writes spaces into every screen cell,
// with req_stall high; the cursor starts at row 1, column 1.
// A stalled response holds in the output register; the next request is
// only taken once the block is idle, and its result waits for the slot.
module text_console_char_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tccw_pkg::OP_W-1:0]     req_op,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tccw_pkg::COL_W-1:0]    req_read_column,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccw_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_column
);
   import tccw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: picks the cell walk for each request
   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // screen memory, cursor, scroll pointer and response register
   tccw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column)
   );

endmodule

// ===== src/tccw_ctrl.sv =====
`timescale 1ns / 1ps

module tccw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tccw_pkg::status_type status,
   output tccw_pkg::cmd_type    cmd
);
   import tccw_pkg::*;

   localparam logic [3:0] ST_INIT        = 4'd0;
   localparam logic [3:0] ST_IDLE        = 4'd1;
   localparam logic [3:0] ST_EXEC        = 4'd2;
   localparam logic [3:0] ST_PAD_TAB     = 4'd3;
   localparam logic [3:0] ST_PAD_NL      = 4'd4;
   localparam logic [3:0] ST_SCROLL_PRE  = 4'd5;
   localparam logic [3:0] ST_SCROLL_POST = 4'd6;
   localparam logic [3:0] ST_READ        = 4'd7;
   localparam logic [3:0] ST_CLEAR       = 4'd8;
   localparam logic [3:0] ST_OUT         = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      logic done;
      done      = 1'b0;
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_INIT: begin
            cmd.sweep_clear = 1'b1;
            if (status.sweep_last_cell) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.op)
               OP_PRINT: begin
                  if (status.row_at_end) begin
                     state_in = ST_SCROLL_PRE;
                  end else if (status.is_tab && !status.col_ge_tab) begin
                     state_in = ST_PAD_TAB;
                  end else if (status.is_tab || status.is_nl) begin
                     state_in = ST_PAD_NL;
                  end else begin
                     cmd.put = 1'b1;
                     if (status.col_last && status.row_last) begin
                        state_in = ST_SCROLL_POST;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               OP_READ: begin
                  cmd.read = 1'b1;
                  state_in = ST_READ;
               end
               OP_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_PAD_TAB: begin
            cmd.pad = 1'b1;
            if (status.phase_last) begin
               done = 1'b1;
            end
         end
         ST_PAD_NL: begin
            cmd.pad = 1'b1;
            if (status.col_last) begin
               done = 1'b1;
            end
         end
         ST_SCROLL_PRE: begin
            cmd.scroll_fill = 1'b1;
            if (status.sweep_last_col) begin
               cmd.scroll_end = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_SCROLL_POST: begin
            cmd.scroll_fill = 1'b1;
            if (status.sweep_last_col) begin
               cmd.scroll_end = 1'b1;
               done           = 1'b1;
            end
         end
         ST_READ: begin
            done = 1'b1;
         end
         ST_CLEAR: begin
            cmd.sweep_clear = 1'b1;
            if (status.sweep_last_cell) begin
               cmd.home = 1'b1;
               done     = 1'b1;
            end
         end
         ST_OUT: begin
            done = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (status.rsp_free) begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end else begin
            state_in = ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/tccw_datapath.sv =====
`timescale 1ns / 1ps

module tccw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tccw_pkg::cmd_type             cmd,
   output tccw_pkg::status_type          status,
   input  logic [tccw_pkg::OP_W-1:0]     req_op,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::ROW_W-1:0]    req_read_row,
   input  logic [tccw_pkg::COL_W-1:0]    req_read_column,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [tccw_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_column
);
   import tccw_pkg::*;

   // logical row + top pointer, folded modulo ROWS, to a linear cell address
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] lrow,
                                                   input logic [ROW_W-1:0] top,
                                                   input logic [COL_W-1:0] col);
      logic [ROW_W:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return ADDR_W'(sum) * ADDR_W'(COLS) + ADDR_W'(col);
   endfunction

   logic [CHAR_W-1:0] screen_mem [CELLS];
   logic [CHAR_W-1:0] rd_data_ff;

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;

   // cursor and scroll state
   logic [ROW_W-1:0]   row_ff,   row_in;
   logic [COL_W-1:0]   col_ff,   col_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROW_W-1:0]   top_ff,   top_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;

   logic [CHAR_W-1:0] rsp_cell_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [CHAR_W-1:0] wdata;
   logic [ADDR_W-1:0] raddr;
   logic              range_ok;
   logic              advance;

   assign range_ok = (rrow_ff < ROW_W'(ROWS)) && (rcol_ff < COL_W'(COLS));
   assign advance  = cmd.pad || cmd.put;

   always_comb begin
      status.op              = op_ff;
      status.is_tab          = (char_ff == CH_TAB);
      status.is_nl           = (char_ff == CH_NL);
      status.row_at_end      = (row_ff == ROW_W'(ROWS));
      status.row_last        = (row_ff == ROW_W'(ROWS - 1));
      status.col_last        = (col_ff == COL_W'(COLS - 1));
      status.col_ge_tab      = (col_ff >= COL_W'(COLS - TAB_WIDTH));
      status.phase_last      = (phase_ff == PHASE_W'(TAB_WIDTH - 1));
      status.sweep_last_cell = (sweep_ff == ADDR_W'(CELLS - 1));
      status.sweep_last_col  = (sweep_ff == ADDR_W'(COLS - 1));
      status.rsp_free        = !rsp_valid_ff || !rsp_stall;
   end

   // write port
   always_comb begin
      we    = cmd.sweep_clear || cmd.scroll_fill || advance;
      wdata = CH_SPACE;
      if (cmd.scroll_fill) begin
         wdata = CH_NULL;
      end else if (cmd.put) begin
         wdata = char_ff;
      end
      if (cmd.sweep_clear) begin
         waddr = sweep_ff;
      end else if (cmd.scroll_fill) begin
         waddr = cell_addr('0, top_ff, sweep_ff[COL_W-1:0]);
      end else begin
         waddr = cell_addr(row_ff, top_ff, col_ff);
      end
      raddr = cell_addr(rrow_ff, top_ff, rcol_ff);
   end

   // cursor, top pointer and sweep
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      top_in   = top_ff;
      sweep_in = sweep_ff;

      if (cmd.sweep_clear) begin
         sweep_in = status.sweep_last_cell ? '0 : sweep_ff + 1'b1;
      end else if (cmd.scroll_fill) begin
         sweep_in = status.sweep_last_col ? '0 : sweep_ff + 1'b1;
      end

      if (cmd.home) begin
         row_in   = '0;
         col_in   = '0;
         phase_in = '0;
         top_in   = '0;
      end else if (cmd.scroll_end) begin
         row_in = row_ff - 1'b1;
         top_in = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
      end else if (advance) begin
         if (status.col_last) begin
            row_in   = row_ff + 1'b1;
            col_in   = '0;
            phase_in = '0;
         end else begin
            col_in   = col_ff + 1'b1;
            phase_in = status.phase_last ? '0 : phase_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= ROW_W'(1);
         col_ff       <= COL_W'(1);
         phase_ff     <= PHASE_W'(1);
         top_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_column;
      end
      if (cmd.finish) begin
         rsp_cell_ff <= (op_ff == OP_READ && range_ok) ? rd_data_ff : CH_NULL;
         rsp_row_ff  <= row_in;
         rsp_col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         screen_mem[waddr] <= wdata;
      end
      if (cmd.read && range_ok) begin
         rd_data_ff <= screen_mem[raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_char     = rsp_cell_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;

endmodule
